/* rtl/mssq_pkg.sv */
// Shared types and constants for the motor soft start/stop sequencer.
package mssq_pkg;

    // Motor phase, as shown on the phase output
    typedef enum logic [1:0] {
        PH_OFF      = 2'd0,
        PH_STARTING = 2'd1,
        PH_RUNNING  = 2'd2,
        PH_BRAKING  = 2'd3
    } phase_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_COMMIT
    } ctrl_state_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_TOTAL      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HALF_PERIOD = 2'd2;

    // Register reset values
    localparam logic [3:0]  STEPS_TOTAL_RST      = 4'd10;
    localparam logic [15:0] STEP_TICKS_RST       = 16'd8000;
    localparam logic [15:0] BASE_HALF_PERIOD_RST = 16'd4000;

    // Widths
    localparam int unsigned TICK_W = 16;
    localparam int unsigned STEP_W = 4;
    localparam int unsigned DIV_W  = STEP_W + 1;
    localparam int unsigned CNT_W  = 4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch the poll and seed the divider
        logic div_step;  // one restoring divider iteration
        logic commit;    // apply the phase update
    } mssq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;  // last divider iteration in progress
    } mssq_stat_t;

endpackage

/* rtl/motor_soft_start_stop_sequencer.sv */
// Top level of the motor soft start/stop sequencer.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid / in_ready   | elapsed_ticks, start_pressed, stop_pressed
//   out     | out_valid / out_ready | run_lamp, stop_lamp, phase, ramp_step
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The accepting edge latches the poll, the restoring divider then forms the blink
// half period, and the commit step applies the update. The next poll is accepted
// in the cycle after commit.
// Reset puts the motor off with the stop lamp lit and loads the register
// defaults. A stalled result stays on the output ports; a new poll is still
// accepted and divided, and its commit waits until the result is taken.
// Configuration writes are taken in every cycle.
module motor_soft_start_stop_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    // poll transaction
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [15:0]                       elapsed_ticks,
    input  logic                              start_pressed,
    input  logic                              stop_pressed,
    // result transaction
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              run_lamp,
    output logic                              stop_lamp,
    output logic [1:0]                        phase,
    output logic [3:0]                        ramp_step,
    // register write transaction
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mssq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data
);

    mssq_pkg::mssq_cmd_t  cmd;
    mssq_pkg::mssq_stat_t stat;

    // Registers never back-pressure the write channel.
    assign cfg_ready = 1'b1;

    // Sequence each poll: latch, divide, commit when the result slot is free.
    mssq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the phase state; the state registers double as the result register,
    // since they change only on commit, which never overwrites an untaken result.
    mssq_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .elapsed_ticks (elapsed_ticks),
        .start_pressed (start_pressed),
        .stop_pressed  (stop_pressed),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .run_lamp      (run_lamp),
        .stop_lamp     (stop_lamp),
        .phase         (phase),
        .ramp_step     (ramp_step)
    );

endmodule

/* rtl/mssq_ctrl.sv */
// Controller state machine for the sequencer: accept, divide, commit.
module mssq_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  mssq_pkg::mssq_stat_t   stat,
    output mssq_pkg::mssq_cmd_t    cmd
);

    mssq_pkg::ctrl_state_t state_reg;
    mssq_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mssq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            mssq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mssq_pkg::ST_DIVIDE;
                end
            end
            mssq_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = mssq_pkg::ST_COMMIT;
                end
            end
            mssq_pkg::ST_COMMIT:
            begin
                // hold until the result slot is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mssq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mssq_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/mssq_dp.sv */
// Datapath for the sequencer: registers, half-period divider, ramp update.
module mssq_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mssq_pkg::mssq_cmd_t               cmd,
    output mssq_pkg::mssq_stat_t              stat,
    input  logic [mssq_pkg::TICK_W-1:0]       elapsed_ticks,
    input  logic                              start_pressed,
    input  logic                              stop_pressed,
    input  logic                              cfg_we,
    input  logic [mssq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mssq_pkg::TICK_W-1:0]       cfg_data,
    output logic                              run_lamp,
    output logic                              stop_lamp,
    output logic [1:0]                        phase,
    output logic [mssq_pkg::STEP_W-1:0]       ramp_step
);

    localparam int unsigned TW = mssq_pkg::TICK_W;
    localparam int unsigned SW = mssq_pkg::STEP_W;
    localparam int unsigned DW = mssq_pkg::DIV_W;
    localparam int unsigned CW = mssq_pkg::CNT_W;

    // configuration
    logic [SW-1:0] steps_total_reg;
    logic [TW-1:0] step_ticks_reg;
    logic [TW-1:0] base_half_reg;

    // poll latch
    logic [TW-1:0] ticks_reg;
    logic          start_reg;
    logic          stop_reg;

    // divider
    logic [DW-1:0] div_reg;
    logic [DW-1:0] div_next;
    logic [DW-1:0] rem_reg;
    logic [TW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          quo_bit;

    // sequencer state
    mssq_pkg::phase_t phase_reg;
    mssq_pkg::phase_t phase_next;
    logic [SW-1:0]    step_count_reg;
    logic [SW-1:0]    step_count_next;
    logic [TW-1:0]    step_accum_reg;
    logic [TW-1:0]    step_accum_next;
    logic [TW-1:0]    blink_accum_reg;
    logic [TW-1:0]    blink_accum_next;
    logic             blink_toggle_reg;
    logic             blink_toggle_next;
    logic             run_lamp_reg;
    logic             run_lamp_next;
    logic             stop_lamp_reg;
    logic             stop_lamp_next;

    logic [TW-1:0] step_sum;
    logic [TW-1:0] blink_sum;
    logic [SW-1:0] step_inc;
    logic          ramp_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_total_reg <= mssq_pkg::STEPS_TOTAL_RST;
            step_ticks_reg  <= mssq_pkg::STEP_TICKS_RST;
            base_half_reg   <= mssq_pkg::BASE_HALF_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mssq_pkg::CFG_STEPS_TOTAL:      steps_total_reg <= cfg_data[SW-1:0];
                mssq_pkg::CFG_STEP_TICKS:       step_ticks_reg  <= cfg_data;
                mssq_pkg::CFG_BASE_HALF_PERIOD: base_half_reg   <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // divisor for this poll, from the phase and step before the update
    always_comb
    begin
        div_next = DW'(1);
        if (phase_reg == mssq_pkg::PH_STARTING)
        begin
            div_next = {1'b0, step_count_reg} + DW'(1);
        end
        else if (steps_total_reg > step_count_reg)
        begin
            div_next = {1'b0, steps_total_reg - step_count_reg};
        end
    end

    // restoring divider step: remainder stays below the divisor
    assign trial   = {rem_reg, quo_reg[TW-1]};
    assign diff    = trial - {1'b0, div_reg};
    assign quo_bit = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ticks_reg <= elapsed_ticks;
            start_reg <= start_pressed;
            stop_reg  <= stop_pressed;
            div_reg   <= div_next;
            rem_reg   <= '0;
            quo_reg   <= base_half_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= quo_bit ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[TW-2:0], quo_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    assign stat.div_done = cmd.div_step && (cnt_reg == CW'(TW - 1));

    // phase update, quo_reg holds the half period
    assign step_sum  = step_accum_reg + ticks_reg;
    assign blink_sum = blink_accum_reg + ticks_reg;
    assign step_inc  = (step_count_reg == '1) ? step_count_reg : step_count_reg + SW'(1);

    always_comb
    begin
        phase_next        = phase_reg;
        step_count_next   = step_count_reg;
        step_accum_next   = step_accum_reg;
        blink_accum_next  = blink_accum_reg;
        blink_toggle_next = blink_toggle_reg;
        run_lamp_next     = run_lamp_reg;
        stop_lamp_next    = stop_lamp_reg;
        ramp_done         = 1'b0;
        unique case (phase_reg)
            mssq_pkg::PH_OFF:
            begin
                if (start_reg)
                begin
                    stop_lamp_next    = 1'b0;
                    step_count_next   = '0;
                    step_accum_next   = '0;
                    blink_accum_next  = '0;
                    blink_toggle_next = 1'b0;
                    phase_next        = mssq_pkg::PH_STARTING;
                end
            end
            mssq_pkg::PH_RUNNING:
            begin
                if (stop_reg)
                begin
                    step_count_next   = '0;
                    step_accum_next   = '0;
                    blink_accum_next  = '0;
                    blink_toggle_next = 1'b0;
                    phase_next        = mssq_pkg::PH_BRAKING;
                end
            end
            mssq_pkg::PH_STARTING,
            mssq_pkg::PH_BRAKING:
            begin
                blink_accum_next = blink_sum;
                if (blink_sum >= quo_reg)
                begin
                    blink_accum_next  = '0;
                    run_lamp_next     = blink_toggle_reg;
                    blink_toggle_next = !blink_toggle_reg;
                end
                step_accum_next = step_sum;
                if (step_sum >= step_ticks_reg)
                begin
                    step_accum_next = '0;
                    step_count_next = step_inc;
                    ramp_done       = (step_inc >= steps_total_reg);
                end
                if (ramp_done)
                begin
                    if (phase_reg == mssq_pkg::PH_STARTING)
                    begin
                        run_lamp_next = 1'b1;
                        phase_next    = mssq_pkg::PH_RUNNING;
                    end
                    else
                    begin
                        run_lamp_next  = 1'b0;
                        stop_lamp_next = 1'b1;
                        phase_next     = mssq_pkg::PH_OFF;
                    end
                end
            end
            default:
            begin
                phase_next = mssq_pkg::PH_OFF;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= mssq_pkg::PH_OFF;
            step_count_reg   <= '0;
            step_accum_reg   <= '0;
            blink_accum_reg  <= '0;
            blink_toggle_reg <= 1'b0;
            run_lamp_reg     <= 1'b0;
            stop_lamp_reg    <= 1'b1;
        end
        else if (cmd.commit)
        begin
            phase_reg        <= phase_next;
            step_count_reg   <= step_count_next;
            step_accum_reg   <= step_accum_next;
            blink_accum_reg  <= blink_accum_next;
            blink_toggle_reg <= blink_toggle_next;
            run_lamp_reg     <= run_lamp_next;
            stop_lamp_reg    <= stop_lamp_next;
        end
    end

    assign run_lamp  = run_lamp_reg;
    assign stop_lamp = stop_lamp_reg;
    assign phase     = phase_reg;
    assign ramp_step = step_count_reg;

endmodule

/* rtl/mssq_chk.sv */
// Port-level checker for the sequencer, bound to the top level.
module mssq_chk
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              run_lamp,
    input logic                              stop_lamp,
    input logic [1:0]                        phase,
    input logic [3:0]                        ramp_step
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(ramp_step)
            && $stable(run_lamp) && $stable(stop_lamp))
        else $error("stalled result changed");

    // one poll at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("poll accepted while busy");

    // stop lamp is lit exactly when the motor is off
    a_stop_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        stop_lamp == (phase == mssq_pkg::PH_OFF))
        else $error("stop lamp disagrees with phase");

    // running shows a steady run lamp
    a_run_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        phase == mssq_pkg::PH_RUNNING |-> run_lamp)
        else $error("run lamp dark while running");

endmodule

bind motor_soft_start_stop_sequencer mssq_chk u_mssq_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .run_lamp  (run_lamp),
    .stop_lamp (stop_lamp),
    .phase     (phase),
    .ramp_step (ramp_step)
);
